### rtl/lcs_pkg.sv
`default_nettype none

package lcs_pkg;

	localparam int MAX_FIRST_LEN_DEF = 256;

	localparam int ACTION_W  = 2;
	localparam int SYMBOL_W  = 8;
	localparam int OUT_LEN_W = 9;

	localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SECOND     = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FINISH     = 2'd2;

	localparam logic [OUT_LEN_W-1:0] LEN_OUT_MAX = 9'd511;

	typedef struct packed {
		logic load;
		logic clear;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/lcs_feed_if.sv
`default_nettype none

interface lcs_feed_if;
	logic                          valid;
	logic                          ready;
	logic [lcs_pkg::ACTION_W-1:0] action;
	logic [lcs_pkg::SYMBOL_W-1:0] symbol;

	modport source (output valid, output action, output symbol, input ready);
	modport sink   (input valid, input action, input symbol, output ready);
endinterface

`default_nettype wire

### rtl/lcs_result_if.sv
`default_nettype none

interface lcs_result_if;
	logic                           valid;
	logic                           ready;
	logic [lcs_pkg::OUT_LEN_W-1:0] lcs_length;
	logic                           overflow;

	modport source (output valid, output lcs_length, output overflow, input ready);
	modport sink   (input valid, input lcs_length, input overflow, output ready);
endinterface

`default_nettype wire

### rtl/lcs_cell.sv
`default_nettype none

module lcs_cell #(
	parameter int LEN_W = 9
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lcs_pkg::cell_ctl_t            ctl,
	input  wire logic [lcs_pkg::SYMBOL_W-1:0] load_sym,
	input  wire logic [LEN_W-1:0]              load_len,
	input  wire logic                          tok_valid,
	input  wire logic [lcs_pkg::SYMBOL_W-1:0] tok_sym,
	input  wire logic [LEN_W-1:0]              tok_left,
	input  wire logic [LEN_W-1:0]              tok_diag,
	output logic                               nxt_valid,
	output logic [lcs_pkg::SYMBOL_W-1:0]      nxt_sym,
	output logic [LEN_W-1:0]                   nxt_left,
	output logic [LEN_W-1:0]                   nxt_diag
);

	logic                          used_q;
	logic [lcs_pkg::SYMBOL_W-1:0] sym_q;
	logic [LEN_W-1:0]              len_q;
	logic [LEN_W-1:0]              cell_val;

	always_comb begin
		if (sym_q == tok_sym) begin
			cell_val = LEN_W'(tok_diag + 1'b1);
		end else if (len_q > tok_left) begin
			cell_val = len_q;
		end else begin
			cell_val = tok_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			len_q     <= '0;
			nxt_valid <= 1'b0;
			nxt_left  <= '0;
		end else if (ctl.clear) begin
			used_q    <= 1'b0;
			len_q     <= '0;
			nxt_valid <= 1'b0;
			nxt_left  <= '0;
		end else if (ctl.load) begin
			used_q    <= 1'b1;
			len_q     <= load_len;
			nxt_valid <= tok_valid;
		end else begin
			nxt_valid <= tok_valid;
			if (tok_valid) begin
				if (used_q) begin
					len_q    <= cell_val;
					nxt_left <= cell_val;
				end else begin
					nxt_left <= tok_left;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sym_q <= load_sym;
		end
		if (tok_valid) begin
			nxt_sym  <= tok_sym;
			nxt_diag <= len_q;
		end
	end

endmodule

`default_nettype wire

### rtl/lcs_length_engine.sv
// LCS length engine: length of the longest common subsequence of two byte strings.
// feed (sink): one beat per symbol. action selects load of a first-string symbol,
//   a second-string symbol, or finish; action code 3 is taken and ignored.
// result (source): one beat per finish, carrying lcs_length and overflow.
// First-string symbols sit one per cell in a chain of MAX_FIRST_LEN cells; symbols
//   beyond capacity are dropped and raise overflow for the current pair.
// Second-string symbols are taken one per cycle and ripple down the chain as a
//   skewed wavefront, one cell per cycle; each cell updates its column in passing.
// A load or finish beat waits until the last wavefront has left the chain, as the
//   drain counter reloaded by each second-string symbol shows when it reaches zero;
//   with no wavefront in flight it is taken at once.
// The result is registered: it appears the cycle after the finish beat. A finish
//   also clears the pair state, so the next pair may start on the following cycle.
// A stalled result holds feed.ready low for a further finish only; loads and
//   second-string symbols are still taken.
// Reset clears all cells, the counters, overflow and the result valid flag.
`default_nettype none

module lcs_length_engine #(
	parameter int MAX_FIRST_LEN = lcs_pkg::MAX_FIRST_LEN_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lcs_feed_if.sink     feed,
	lcs_result_if.source result
);

	localparam int CNT_W = $clog2(MAX_FIRST_LEN + 1);

	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              drain_q;
	logic                          ovf_q;
	logic                          head_valid_q;
	logic [lcs_pkg::SYMBOL_W-1:0] head_sym_q;
	logic                          res_valid_q;
	logic [lcs_pkg::OUT_LEN_W-1:0] res_len_q;
	logic                          res_ovf_q;

	logic                          take;
	logic                          is_load;
	logic                          is_second;
	logic                          is_finish;
	logic                          drained;
	logic [CNT_W-1:0]              tail_len;
	logic [31:0]                   tail_ext;
	logic [lcs_pkg::OUT_LEN_W-1:0] tail_sat;

	logic                          tv  [MAX_FIRST_LEN+1];
	logic [lcs_pkg::SYMBOL_W-1:0] ts  [MAX_FIRST_LEN+1];
	logic [CNT_W-1:0]              tl  [MAX_FIRST_LEN+1];
	logic [CNT_W-1:0]              td  [MAX_FIRST_LEN+1];

	assign is_load   = (feed.action == lcs_pkg::ACT_LOAD_FIRST);
	assign is_second = (feed.action == lcs_pkg::ACT_SECOND);
	assign is_finish = (feed.action == lcs_pkg::ACT_FINISH);
	assign drained   = (drain_q == '0);

	always_comb begin
		if (is_load) begin
			feed.ready = drained;
		end else if (is_finish) begin
			feed.ready = drained && (!res_valid_q || result.ready);
		end else begin
			feed.ready = 1'b1;
		end
	end

	assign take = feed.valid && feed.ready;

	assign tv[0] = head_valid_q;
	assign ts[0] = head_sym_q;
	assign tl[0] = '0;
	assign td[0] = '0;

	assign tail_len = tl[MAX_FIRST_LEN];
	assign tail_ext = 32'(tail_len);
	assign tail_sat = (tail_ext > 32'(lcs_pkg::LEN_OUT_MAX)) ? lcs_pkg::LEN_OUT_MAX
		: tail_ext[lcs_pkg::OUT_LEN_W-1:0];

	for (genvar j = 0; j < MAX_FIRST_LEN; j++) begin : g_cell
		lcs_pkg::cell_ctl_t ctl;

		assign ctl.clear = take && is_finish;
		assign ctl.load  = take && is_load && (count_q == CNT_W'(j));

		lcs_cell #(
			.LEN_W(CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.load_sym (feed.symbol),
			.load_len (tail_len),
			.tok_valid(tv[j]),
			.tok_sym  (ts[j]),
			.tok_left (tl[j]),
			.tok_diag (td[j]),
			.nxt_valid(tv[j+1]),
			.nxt_sym  (ts[j+1]),
			.nxt_left (tl[j+1]),
			.nxt_diag (td[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			drain_q      <= '0;
			ovf_q        <= 1'b0;
			head_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			head_valid_q <= take && is_second;
			if (take && is_second) begin
				drain_q <= CNT_W'(MAX_FIRST_LEN);
			end else if (!drained) begin
				drain_q <= drain_q - 1'b1;
			end
			if (take && is_load) begin
				if (count_q == CNT_W'(MAX_FIRST_LEN)) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (take && is_finish) begin
				count_q     <= '0;
				ovf_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_second) begin
			head_sym_q <= feed.symbol;
		end
		if (take && is_finish) begin
			res_len_q <= tail_sat;
			res_ovf_q <= ovf_q;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.lcs_length = res_len_q;
	assign result.overflow   = res_ovf_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FIRST_LEN))
		else $error("column count beyond capacity");

	a_drain_range: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q <= CNT_W'(MAX_FIRST_LEN))
		else $error("drain counter beyond chain length");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (is_finish || is_load)) |-> (drain_q == '0))
		else $error("load or finish taken with wavefront in flight");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_finish) |=> (res_valid_q && count_q == '0 && !ovf_q))
		else $error("finish did not raise result or clear pair state");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> res_valid_q)
		else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire
